// ===== hdl/pcebp_pkg.sv =====
// Shared constants and types of the prefix-code encoder and bit packer.
`timescale 1ns / 1ps

package pcebp_pkg;

  localparam int TABLE_DEPTH  = 256;
  localparam int MAX_CODE_LEN = 32;
  localparam int CODE_WIDTH   = 32;
  localparam int ADDR_W       = $clog2(TABLE_DEPTH);
  localparam int CODE_LEN_CAP = (MAX_CODE_LEN < CODE_WIDTH) ? MAX_CODE_LEN : CODE_WIDTH;

  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_ENCODE = 2'd1,
    ACT_SERIAL = 2'd2,
    ACT_FINISH = 2'd3
  } action_e;

  typedef struct packed {
    logic [7:0]  sym;
    logic [31:0] code;
    logic [5:0]  len;
  } entry_t;

  // Requests from the sequencer to the packer.
  typedef struct packed {
    logic        load;
    logic        flush;
    logic [31:0] val;
    logic [5:0]  len;
  } pk_ctrl_t;

  // Status reported by the packer.
  typedef struct packed {
    logic       busy;
    logic       hold_vld;
    logic [2:0] pend_cnt;
  } pk_stat_t;

endpackage

// ===== hdl/pcebp_packer.sv =====
// MSB-first bit packer with a one-byte hold stage and an output register.
`timescale 1ns / 1ps

module pcebp_packer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pcebp_pkg::pk_ctrl_t ctrl_i,
  output pcebp_pkg::pk_stat_t stat_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          out_byte_o,
  output logic                last_o
);

  logic [31:0] val_q, val_d;
  logic [5:0]  rem_q, rem_d;
  logic [6:0]  pend_q, pend_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [7:0]  hold_q, hold_d;
  logic        hold_vld_q, hold_vld_d;
  logic [7:0]  out_q, out_d;
  logic        out_last_q, out_last_d;
  logic        out_vld_q, out_vld_d;

  logic        out_free;
  logic [3:0]  space;
  logic [3:0]  w;
  logic        step;
  logic [5:0]  sh;
  logic [31:0] shifted;
  logic [7:0]  mask;
  logic [7:0]  chunk;
  logic [14:0] acc;
  logic [3:0]  sum;
  logic        full;

  assign out_free = !out_vld_q || !out_stall_i;
  assign space    = 4'd8 - {1'b0, cnt_q};
  assign w        = (rem_q < {2'b00, space}) ? rem_q[3:0] : space;
  assign step     = (rem_q != 6'd0) && (!hold_vld_q || out_free);
  assign sh       = rem_q - {2'b00, w};
  // The shared shifter brings the next bits of the codeword down to the bottom.
  assign shifted  = val_q >> sh;
  assign mask     = 8'((9'd1 << w) - 9'd1);
  assign chunk    = shifted[7:0] & mask;
  assign acc      = ({8'd0, pend_q} << w) | {7'd0, chunk};
  assign sum      = {1'b0, cnt_q} + w;
  assign full     = (sum == 4'd8);

  always_comb begin
    val_d      = val_q;
    rem_d      = rem_q;
    pend_d     = pend_q;
    cnt_d      = cnt_q;
    hold_d     = hold_q;
    hold_vld_d = hold_vld_q;
    out_d      = out_q;
    out_last_d = out_last_q;
    out_vld_d  = out_vld_q && out_stall_i;
    if (ctrl_i.load) begin
      val_d = ctrl_i.val;
      rem_d = ctrl_i.len;
    end else if (step) begin
      rem_d = sh;
      if (full) begin
        pend_d     = 7'd0;
        cnt_d      = 3'd0;
        hold_d     = acc[7:0];
        hold_vld_d = 1'b1;
        // A byte already held cannot be the last one of the item, so it moves on.
        if (hold_vld_q) begin
          out_d      = hold_q;
          out_last_d = 1'b0;
          out_vld_d  = 1'b1;
        end
      end else begin
        pend_d = acc[6:0];
        cnt_d  = sum[2:0];
      end
    end else if (ctrl_i.flush && hold_vld_q && out_free) begin
      out_d      = hold_q;
      out_last_d = 1'b1;
      out_vld_d  = 1'b1;
      hold_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q      <= 6'd0;
      pend_q     <= 7'd0;
      cnt_q      <= 3'd0;
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      rem_q      <= rem_d;
      pend_q     <= pend_d;
      cnt_q      <= cnt_d;
      hold_vld_q <= hold_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q      <= val_d;
    hold_q     <= hold_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign stat_o.busy     = (rem_q != 6'd0);
  assign stat_o.hold_vld = hold_vld_q;
  assign stat_o.pend_cnt = cnt_q;
  assign out_valid_o     = out_vld_q;
  assign out_byte_o      = out_q;
  assign last_o          = out_last_q;

  a_load_when_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.load |-> (rem_q == 6'd0))
    else $error("packer loaded while bits remain");

  a_flush_after_push : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.flush |-> (rem_q == 6'd0))
    else $error("flush requested while bits remain");

  a_flush_marks_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.flush && hold_vld_q && out_free && !ctrl_i.load && rem_q == 6'd0)
      |=> (out_vld_q && out_last_q))
    else $error("flushed byte not marked last");

endmodule

// ===== hdl/prefix_code_encoder_bit_packer_top.sv =====
// Top level of the prefix-code encoder: code table, sequencer and bit packer.
//
// Usage: input items arrive on in_valid_i / in_stall_o with action, entry_index,
// symbol, code_bits and code_length. A transfer takes place when in_valid_i is
// high and in_stall_o is low; in_stall_o is high while an item is being worked.
// Output bytes leave on out_valid_o / out_stall_i, last_o marking the final byte
// of an item. entries_in_use is written through cfg_we_i / cfg_wdata_i.
// Sequencing: a write entry goes to the table as it is accepted. An encode
// compares one entry at a time through the single read port, so a miss scans all
// n entries in use. Each packer segment is moved in chunks of up to 8 bits, and
// an item that emits bytes waits until its last byte leaves the hold stage. A
// serialize out of range emits nothing. The packer moves at most 8 bits a cycle.
// The last byte of an item is held back one stage until it is known to be last.
// Reset clears the sequencer, pending bits, the table bit count and the
// register; the table contents are undefined until written. When the receiver
// stalls, the packer stops once its hold stage and output register are full,
// and the item simply takes longer; nothing is lost.
`timescale 1ns / 1ps

module prefix_code_encoder_bit_packer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  entry_index_i,
  input  logic [7:0]  symbol_i,
  input  logic [31:0] code_bits_i,
  input  logic [5:0]  code_length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        last_o,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,
    S_CMP  = 6'b000100,
    S_LOAD = 6'b001000,
    S_PUSH = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  state_e                  state_q, state_d;
  pcebp_pkg::action_e      act_q, act_d;
  logic [7:0]              sym_q, sym_d;
  logic [8:0]              i_q, i_d;
  logic [1:0]              seg_q, seg_d;
  logic [31:0]             tbc_q, tbc_d;
  logic [8:0]              cfg_q;
  pcebp_pkg::entry_t       mem_q [pcebp_pkg::TABLE_DEPTH];
  pcebp_pkg::entry_t       rdata_q;
  pcebp_pkg::entry_t       wr_entry;
  logic                    wr_en;
  logic                    accept;
  logic [8:0]              n_eff;
  logic [8:0]              i_next;
  logic [5:0]              wr_len;
  logic [3:0]              pad;
  logic [2:0]              pk_ctrl_pad_q;
  pcebp_pkg::pk_ctrl_t     pk_ctrl;
  pcebp_pkg::pk_stat_t     pk_stat;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign n_eff      = (cfg_q > 9'(pcebp_pkg::TABLE_DEPTH)) ? 9'(pcebp_pkg::TABLE_DEPTH) : cfg_q;
  assign i_next     = i_q + 9'd1;
  assign pad        = 4'd8 - {1'b0, pk_stat.pend_cnt};

  assign wr_len = (code_length_i > 6'(pcebp_pkg::CODE_LEN_CAP)) ?
                  6'(pcebp_pkg::CODE_LEN_CAP) : code_length_i;
  assign wr_en  = accept && (pcebp_pkg::action_e'(action_i) == pcebp_pkg::ACT_WRITE) &&
                  ({1'b0, entry_index_i} < 9'(pcebp_pkg::TABLE_DEPTH));
  assign wr_entry.sym  = symbol_i;
  assign wr_entry.code = code_bits_i;
  assign wr_entry.len  = wr_len;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[entry_index_i[pcebp_pkg::ADDR_W-1:0]] <= wr_entry;
    end
    if (state_q == S_RD) begin
      rdata_q <= mem_q[i_q[pcebp_pkg::ADDR_W-1:0]];
    end
  end

  always_comb begin
    state_d       = state_q;
    act_d         = act_q;
    sym_d         = sym_q;
    i_d           = i_q;
    seg_d         = seg_q;
    tbc_d         = tbc_q;
    pk_ctrl.load  = 1'b0;
    pk_ctrl.flush = 1'b0;
    pk_ctrl.val   = 32'd0;
    pk_ctrl.len   = 6'd0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          act_d = pcebp_pkg::action_e'(action_i);
          sym_d = symbol_i;
          seg_d = 2'd0;
          case (pcebp_pkg::action_e'(action_i))
            pcebp_pkg::ACT_ENCODE: begin
              i_d     = 9'd0;
              state_d = (n_eff == 9'd0) ? S_DONE : S_RD;
            end
            pcebp_pkg::ACT_SERIAL: begin
              i_d     = {1'b0, entry_index_i};
              state_d = ({1'b0, entry_index_i} < n_eff) ? S_RD : S_DONE;
            end
            pcebp_pkg::ACT_FINISH: state_d = S_LOAD;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_RD: begin
        state_d = (act_q == pcebp_pkg::ACT_ENCODE) ? S_CMP : S_LOAD;
      end
      S_CMP: begin
        // First matching entry wins; a miss over all entries in use emits nothing.
        if (rdata_q.sym == sym_q) begin
          state_d = S_LOAD;
        end else if (i_next == n_eff) begin
          state_d = S_DONE;
        end else begin
          i_d     = i_next;
          state_d = S_RD;
        end
      end
      S_LOAD: begin
        seg_d   = seg_q + 2'd1;
        state_d = S_PUSH;
        case (act_q)
          pcebp_pkg::ACT_ENCODE: begin
            if (seg_q == 2'd0) begin
              pk_ctrl.load = 1'b1;
              pk_ctrl.val  = rdata_q.code;
              pk_ctrl.len  = rdata_q.len;
            end else begin
              state_d = S_DONE;
            end
          end
          pcebp_pkg::ACT_SERIAL: begin
            case (seg_q)
              2'd0: begin
                pk_ctrl.load = 1'b1;
                pk_ctrl.val  = {24'd0, rdata_q.sym};
                pk_ctrl.len  = 6'd8;
                tbc_d        = tbc_q + 32'd16 + 32'(rdata_q.len);
              end
              2'd1: begin
                pk_ctrl.load = 1'b1;
                pk_ctrl.val  = {26'd0, rdata_q.len};
                pk_ctrl.len  = 6'd8;
              end
              2'd2: begin
                pk_ctrl.load = 1'b1;
                pk_ctrl.val  = rdata_q.code;
                pk_ctrl.len  = rdata_q.len;
              end
              default: state_d = S_DONE;
            endcase
          end
          pcebp_pkg::ACT_FINISH: begin
            case (seg_q)
              2'd0: begin
                pk_ctrl.load = 1'b1;
                pk_ctrl.val  = tbc_q;
                pk_ctrl.len  = 6'd32;
              end
              2'd1: begin
                // Zero padding of eight minus the pending bits; a whole zero byte when aligned.
                pk_ctrl.load = 1'b1;
                pk_ctrl.val  = 32'd0;
                pk_ctrl.len  = {2'b00, pad};
              end
              2'd2: begin
                // The pad count itself, taken before the padding was packed.
                pk_ctrl.load = 1'b1;
                pk_ctrl.val  = 32'(4'd8 - {1'b0, pk_ctrl_pad_q});
                pk_ctrl.len  = 6'd8;
              end
              default: begin
                tbc_d   = 32'd0;
                state_d = S_DONE;
              end
            endcase
          end
          default: state_d = S_DONE;
        endcase
      end
      S_PUSH: begin
        if (!pk_stat.busy) begin
          state_d = S_LOAD;
        end
      end
      S_DONE: begin
        pk_ctrl.flush = 1'b1;
        if (!pk_stat.hold_vld) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Pending count seen when the padding was loaded; the pad is eight minus it.
  always_ff @(posedge clk_i) begin
    if (state_q == S_LOAD && act_q == pcebp_pkg::ACT_FINISH && seg_q == 2'd1) begin
      pk_ctrl_pad_q <= pk_stat.pend_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      tbc_q   <= 32'd0;
      cfg_q   <= 9'd0;
      act_q   <= pcebp_pkg::ACT_WRITE;
      seg_q   <= 2'd0;
      i_q     <= 9'd0;
    end else begin
      state_q <= state_d;
      tbc_q   <= tbc_d;
      act_q   <= act_d;
      seg_q   <= seg_d;
      i_q     <= i_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q <= sym_d;
  end

  pcebp_packer u_packer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (pk_ctrl),
    .stat_o      (pk_stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

  a_read_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD) |-> (i_q < n_eff))
    else $error("table read beyond the entries in use");

  a_load_packer_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD) |-> !pk_stat.busy)
    else $error("segment loaded while the packer is busy");

  a_finish_aligned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && act_q == pcebp_pkg::ACT_FINISH) |-> (pk_stat.pend_cnt == 3'd0))
    else $error("bits left pending after finish");

endmodule
